>>> hw/rtl/dtbrl_pkg.sv
package dtbrl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_LINK_PADDING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_SIZE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_CAP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_CAP   = 3'd4;

	localparam logic [15:0] CELL_CAP_RST   = 16'd16384;
	localparam logic [15:0] STREAM_CAP_RST = 16'd15936;

	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_SET    = 3'd1;
	localparam logic [2:0] MODE_QUERY  = 3'd2;
	localparam logic [2:0] MODE_CHARGE = 3'd3;
	localparam logic [2:0] MODE_WBLOCK = 3'd4;
	localparam logic [2:0] MODE_TICK   = 3'd5;

	// A slot bucket is refilled only while it holds at most this many seconds of its rate.
	localparam logic [34:0] REFILL_HEADROOM = 35'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_REFILL,
		ST_WAKE,
		ST_TERM
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_SET,
		OP_QUERY,
		OP_CHARGE,
		OP_WBLOCK,
		OP_ECHO,
		OP_NULL,
		OP_TICK,
		OP_LOAD,
		OP_REFILL,
		OP_WAKE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic       in_beat;
		logic [2:0] mode;
		logic       slot_ok;
		logic       tick_due;
		logic       wake;
		logic       out_free;
	} stat_t;

	function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
		sat_sub32 = (a >= b) ? (a - b) : 32'd0;
	endfunction

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [30:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {2'b00, b};
		sat_add32 = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

endpackage

>>> hw/rtl/dtbrl_if.sv
interface dtbrl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [3:0]  slot;
	logic [30:0] byte_count;
	logic [31:0] seconds;
	logic        speaks_cells;
	logic        is_open;
	logic [30:0] slot_bandwidth;

	modport source(output valid, mode, slot, byte_count, seconds, speaks_cells, is_open,
		slot_bandwidth, input ready);
	modport sink(input valid, mode, slot, byte_count, seconds, speaks_cells, is_open,
		slot_bandwidth, output ready);
	modport mon(input valid, ready, mode, slot, byte_count, seconds, speaks_cells, is_open,
		slot_bandwidth);
endinterface

interface dtbrl_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_slot;
	logic [31:0] read_limit;
	logic        pause_reading;
	logic        resume_reading;
	logic        resume_writing;
	logic        last;

	modport source(output valid, out_slot, read_limit, pause_reading, resume_reading,
		resume_writing, last, input ready);
	modport sink(input valid, out_slot, read_limit, pause_reading, resume_reading,
		resume_writing, last, output ready);
	modport mon(input valid, ready, out_slot, read_limit, pause_reading, resume_reading,
		resume_writing, last);
endinterface

>>> hw/rtl/dtbrl_ctrl.sv
module dtbrl_ctrl #(
	parameter int MAX_SLOTS = 16,
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dtbrl_pkg::stat_t   stat,
	output dtbrl_pkg::cmd_t    cmd,
	output logic [SLOT_W-1:0]  walk_idx
);
	import dtbrl_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_SLOTS - 1);

	state_t            state_q;
	state_t            state_nxt;
	logic [SLOT_W-1:0] idx_q;
	logic              idx_clr;
	logic              idx_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				state_nxt = stat.in_beat ? ST_EXEC : ST_IDLE;
			end
			ST_EXEC: begin
				if (stat.mode == MODE_TICK) begin
					state_nxt = stat.tick_due ? ST_LOAD : ST_TERM;
				end else if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_LOAD: begin
				state_nxt = ST_REFILL;
			end
			ST_REFILL: begin
				state_nxt = ST_WAKE;
			end
			ST_WAKE: begin
				if (!stat.wake || stat.out_free) begin
					state_nxt = (idx_q == LAST_IDX) ? ST_TERM : ST_LOAD;
				end
			end
			ST_TERM: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.in_ready = 1'b0;
		idx_clr      = 1'b0;
		idx_inc      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			ST_EXEC: begin
				case (stat.mode)
					MODE_INIT: begin
						cmd.op = stat.out_free ? OP_INIT : OP_NONE;
					end
					MODE_SET, MODE_QUERY, MODE_CHARGE, MODE_WBLOCK: begin
						if (!stat.out_free) begin
							cmd.op = OP_NONE;
						end else if (!stat.slot_ok) begin
							cmd.op = OP_ECHO;
						end else if (stat.mode == MODE_SET) begin
							cmd.op = OP_SET;
						end else if (stat.mode == MODE_QUERY) begin
							cmd.op = OP_QUERY;
						end else if (stat.mode == MODE_CHARGE) begin
							cmd.op = OP_CHARGE;
						end else begin
							cmd.op = OP_WBLOCK;
						end
					end
					MODE_TICK: begin
						cmd.op  = OP_TICK;
						idx_clr = 1'b1;
					end
					default: begin
						cmd.op = stat.out_free ? OP_NULL : OP_NONE;
					end
				endcase
			end
			ST_LOAD: begin
				cmd.op = OP_LOAD;
			end
			ST_REFILL: begin
				cmd.op = OP_REFILL;
			end
			ST_WAKE: begin
				cmd.op  = (stat.wake && stat.out_free) ? OP_WAKE : OP_NONE;
				idx_inc = !stat.wake || stat.out_free;
			end
			ST_TERM: begin
				cmd.op = stat.out_free ? OP_NULL : OP_NONE;
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	assign walk_idx = idx_q;

endmodule

>>> hw/rtl/dtbrl_dp.sv
module dtbrl_dp #(
	parameter int MAX_SLOTS = 16,
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dtbrl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtbrl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 req_valid,
	input  logic [2:0]                           req_mode,
	input  logic [3:0]                           req_slot,
	input  logic [30:0]                          req_byte_count,
	input  logic [31:0]                          req_seconds,
	input  logic                                 req_speaks_cells,
	input  logic                                 req_is_open,
	input  logic [30:0]                          req_slot_bandwidth,
	input  dtbrl_pkg::cmd_t                      cmd,
	input  logic [SLOT_W-1:0]                    walk_idx,
	output dtbrl_pkg::stat_t                     stat,
	dtbrl_rsp_if.source                          rsp
);
	import dtbrl_pkg::*;

	localparam logic [6:0] NUM_SLOTS = 7'(MAX_SLOTS);

	// Configuration.
	logic        link_padding_q;
	logic [30:0] refill_rate_q;
	logic [30:0] burst_size_q;
	logic [15:0] cell_cap_q;
	logic [15:0] stream_cap_q;

	// Captured input item.
	logic [2:0]  mode_q;
	logic [3:0]  slot_q;
	logic [30:0] bytes_q;
	logic [31:0] secs_q;
	logic        cells_q;
	logic        opened_q;
	logic [30:0] bw_q;

	// Limiter state.
	logic [31:0]          global_q;
	logic [31:0]          last_sec_q;
	logic [31:0]          rx_bucket_q [MAX_SLOTS];
	logic [30:0]          rate_q      [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] cell_flag_q;
	logic [MAX_SLOTS-1:0] open_flag_q;
	logic [MAX_SLOTS-1:0] want_rd_q;
	logic [MAX_SLOTS-1:0] want_wr_q;

	// Slot loaded for the refill step of a tick.
	logic [31:0] ld_bucket_s1;
	logic [30:0] ld_rate_s1;
	logic [34:0] ld_headroom_s1;
	logic        ld_limited_s1;

	// Output register.
	logic        out_valid_q;
	logic [3:0]  out_slot_q;
	logic [31:0] out_limit_q;
	logic        out_pause_q;
	logic        out_rr_q;
	logic        out_rw_q;
	logic        out_last_q;

	logic              capture;
	logic [SLOT_W-1:0] s_idx;
	logic              s_limited;
	logic [31:0]       cap32;
	logic [31:0]       lim_base;
	logic [31:0]       lim;
	logic [31:0]       g_charged;
	logic [31:0]       r_charged;
	logic              pause;
	logic              tick_due;
	logic [31:0]       g_refilled;
	logic [31:0]       r_refilled;
	logic              w_limited;
	logic              wake;
	logic              emit;
	logic [3:0]        e_slot;
	logic [31:0]       e_limit;
	logic              e_pause;
	logic              e_rr;
	logic              e_rw;

	assign capture   = req_valid && cmd.in_ready;
	assign s_idx     = SLOT_W'(slot_q);
	assign s_limited = cell_flag_q[s_idx] && open_flag_q[s_idx];

	// Query: per-read cap (unless link padding is set) against the global bucket, then the slot bucket.
	assign cap32    = {16'd0, (cell_flag_q[s_idx] ? cell_cap_q : stream_cap_q)};
	assign lim_base = (link_padding_q || cap32 > global_q) ? global_q : cap32;
	assign lim      = (s_limited && lim_base > rx_bucket_q[s_idx]) ? rx_bucket_q[s_idx] : lim_base;

	// Charge: both buckets stop at zero.
	assign g_charged = sat_sub32(global_q, {1'b0, bytes_q});
	assign r_charged = sat_sub32(rx_bucket_q[s_idx], {1'b0, bytes_q});
	assign pause     = (g_charged == 32'd0) || (s_limited && r_charged == 32'd0);

	assign tick_due   = secs_q > last_sec_q;
	assign g_refilled = sat_add32(global_q, refill_rate_q);
	assign r_refilled = sat_add32(ld_bucket_s1, ld_rate_s1);

	assign w_limited = cell_flag_q[walk_idx] && open_flag_q[walk_idx];
	assign wake      = want_rd_q[walk_idx] && (global_q != 32'd0)
		&& (!w_limited || rx_bucket_q[walk_idx] != 32'd0);

	assign stat.in_beat  = capture;
	assign stat.mode     = mode_q;
	assign stat.slot_ok  = {3'b000, slot_q} < NUM_SLOTS;
	assign stat.tick_due = tick_due;
	assign stat.wake     = wake;
	assign stat.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_padding_q <= 1'b0;
			refill_rate_q  <= '0;
			burst_size_q   <= '0;
			cell_cap_q     <= CELL_CAP_RST;
			stream_cap_q   <= STREAM_CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINK_PADDING: link_padding_q <= cfg_data[0];
				CFG_REFILL_RATE:  refill_rate_q  <= cfg_data;
				CFG_BURST_SIZE:   burst_size_q   <= cfg_data;
				CFG_CELL_CAP:     cell_cap_q     <= cfg_data[15:0];
				CFG_STREAM_CAP:   stream_cap_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			mode_q   <= req_mode;
			slot_q   <= req_slot;
			bytes_q  <= req_byte_count;
			secs_q   <= req_seconds;
			cells_q  <= req_speaks_cells;
			opened_q <= req_is_open;
			bw_q     <= req_slot_bandwidth;
		end
		if (cmd.op == OP_LOAD) begin
			ld_bucket_s1   <= rx_bucket_q[walk_idx];
			ld_rate_s1     <= rate_q[walk_idx];
			ld_headroom_s1 <= {4'd0, rate_q[walk_idx]} * REFILL_HEADROOM;
			ld_limited_s1  <= w_limited;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_q    <= '0;
			last_sec_q  <= '0;
			cell_flag_q <= '0;
			open_flag_q <= '0;
			want_rd_q   <= '0;
			want_wr_q   <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				rx_bucket_q[i] <= '0;
				rate_q[i]      <= '0;
			end
		end else begin
			case (cmd.op)
				OP_INIT: begin
					last_sec_q <= secs_q;
					global_q   <= {1'b0, burst_size_q};
				end
				OP_SET: begin
					cell_flag_q[s_idx] <= cells_q;
					open_flag_q[s_idx] <= opened_q;
					rate_q[s_idx]      <= bw_q;
					rx_bucket_q[s_idx] <= {1'b0, bw_q};
					want_rd_q[s_idx]   <= 1'b0;
					want_wr_q[s_idx]   <= 1'b0;
				end
				OP_CHARGE: begin
					global_q <= g_charged;
					if (s_limited) begin
						rx_bucket_q[s_idx] <= r_charged;
					end
					if (pause) begin
						want_rd_q[s_idx] <= 1'b1;
					end
				end
				OP_WBLOCK: begin
					want_wr_q[s_idx] <= 1'b1;
				end
				OP_TICK: begin
					if (tick_due) begin
						last_sec_q <= secs_q;
						if (global_q < {1'b0, burst_size_q}) begin
							global_q <= g_refilled;
						end
					end
				end
				OP_REFILL: begin
					if (ld_limited_s1 && {3'b000, ld_bucket_s1} <= ld_headroom_s1) begin
						rx_bucket_q[walk_idx] <= r_refilled;
					end
				end
				OP_WAKE: begin
					want_rd_q[walk_idx] <= 1'b0;
					want_wr_q[walk_idx] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		emit    = 1'b1;
		e_slot  = 4'd0;
		e_limit = 32'd0;
		e_pause = 1'b0;
		e_rr    = 1'b0;
		e_rw    = 1'b0;
		case (cmd.op)
			OP_INIT, OP_NULL: begin
			end
			OP_SET, OP_WBLOCK, OP_ECHO: begin
				e_slot = slot_q;
			end
			OP_QUERY: begin
				e_slot  = slot_q;
				e_limit = lim;
			end
			OP_CHARGE: begin
				e_slot  = slot_q;
				e_pause = pause;
			end
			OP_WAKE: begin
				e_slot = 4'(walk_idx);
				e_rr   = 1'b1;
				e_rw   = want_wr_q[walk_idx];
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_slot_q  <= e_slot;
			out_limit_q <= e_limit;
			out_pause_q <= e_pause;
			out_rr_q    <= e_rr;
			out_rw_q    <= e_rw;
			// Only wake results are followed by more results of the same item.
			out_last_q  <= (cmd.op != OP_WAKE);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.out_slot       = out_slot_q;
	assign rsp.read_limit     = out_limit_q;
	assign rsp.pause_reading  = out_pause_q;
	assign rsp.resume_reading = out_rr_q;
	assign rsp.resume_writing = out_rw_q;
	assign rsp.last           = out_last_q;

endmodule

>>> hw/rtl/dual_token_bucket_read_limiter_unit.sv
// Read-rate limiter: one global token bucket plus one receiver bucket per connection slot.
// Channels: req carries one command beat (init, slot setup, limit query, bytes read,
// write blocked, one-second tick); rsp returns result beats, the final one with last set.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must do so only
// while no command is in flight; the block itself does not enforce this. An accepted command
// is executed in the state after idle, which for all but a tick waits until the output
// register is free; a non-tick command's single result is then registered there. A tick that
// advances time walks every slot through the shared refill logic, one slot after another in
// the states load, refill and wake check, then sends the terminator beat; each woken slot
// adds a result beat ahead of the terminator. Only one command is worked on at a time:
// req.ready is high only between commands. When the receiver stalls, the held result stays
// in the output register and each result-producing step waits until it is taken, so nothing is
// lost or repeated. Reset clears both buckets, the time stamp and all slot state; the per-read
// caps return to 16384 (cell-speaking) and 15936 (other) bytes, other settings to zero.
module dual_token_bucket_read_limiter_unit #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dtbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtbrl_pkg::CFG_DATA_W-1:0] cfg_data,
	dtbrl_req_if.sink                        req,
	dtbrl_rsp_if.source                      rsp
);
	import dtbrl_pkg::*;

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	cmd_t              cmd;
	stat_t             stat;
	logic [SLOT_W-1:0] walk_idx;

	assign req.ready = cmd.in_ready;

	dtbrl_ctrl #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat    (stat),
		.cmd     (cmd),
		.walk_idx(walk_idx)
	);

	dtbrl_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_valid         (req.valid),
		.req_mode          (req.mode),
		.req_slot          (req.slot),
		.req_byte_count    (req.byte_count),
		.req_seconds       (req.seconds),
		.req_speaks_cells  (req.speaks_cells),
		.req_is_open       (req.is_open),
		.req_slot_bandwidth(req.slot_bandwidth),
		.cmd               (cmd),
		.walk_idx          (walk_idx),
		.stat              (stat),
		.rsp               (rsp)
	);

endmodule

>>> hw/rtl/dtbrl_checker.sv
module dtbrl_checker (
	input logic         clk,
	input logic         arst_n,
	dtbrl_req_if.sink   req,
	dtbrl_rsp_if.source rsp
);

	// One command at a time: the beat that is taken closes the request side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a command was in flight");

	// Every result before the terminator is a wake-up.
	a_mid_is_wake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.resume_reading && !rsp.pause_reading
			&& rsp.read_limit == 32'd0)
		else $error("non-final result that is not a wake-up");

	// A write is only restarted together with a read.
	a_write_with_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.resume_writing |-> rsp.resume_reading && !rsp.last)
		else $error("write restart without read restart");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.read_limit)
			&& $stable(rsp.out_slot) && $stable(rsp.last))
		else $error("stalled result changed");

endmodule

bind dual_token_bucket_read_limiter_unit dtbrl_checker u_dtbrl_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.req   (req),
	.rsp   (rsp)
);

>>> tb/dual_token_bucket_read_limiter_unit_test.sv
`timescale 1ns / 1ps

module dual_token_bucket_read_limiter_unit_test;

	localparam int SLOTS = 16;
	localparam int HEADROOM_SECS = 9;
	localparam int LIMIT_CYCLES = 1000000;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  slot;
		logic [30:0] byte_count;
		logic [31:0] seconds;
		logic        speaks_cells;
		logic        is_open;
		logic [30:0] slot_bandwidth;
	} limiter_cmd_t;

	typedef struct packed {
		logic [3:0]  out_slot;
		logic [31:0] read_limit;
		logic        pause_reading;
		logic        resume_reading;
		logic        resume_writing;
		logic        last;
	} limiter_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [dtbrl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dtbrl_pkg::CFG_DATA_W-1:0] cfg_data;

	dtbrl_req_if req_ch();
	dtbrl_rsp_if rsp_ch();

	dual_token_bucket_read_limiter_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the limiter's registers and bucket state.
	logic        lim_pad;
	logic [30:0] lim_rate;
	logic [30:0] lim_burst;
	logic [15:0] lim_cell_cap;
	logic [15:0] lim_stream_cap;
	logic [31:0] glob_tokens;
	logic [31:0] stamp_sec;
	logic [31:0] slot_tokens [SLOTS];
	logic [30:0] slot_refill [SLOTS];
	logic        slot_cells [SLOTS];
	logic        slot_open [SLOTS];
	logic        read_waiting [SLOTS];
	logic        write_waiting [SLOTS];

	limiter_cmd_t  pending_cmds [$];
	limiter_beat_t awaited_beats [$];
	limiter_cmd_t  in_flight;
	limiter_beat_t got_beat;
	limiter_beat_t want_beat;

	int  gap_left;
	int  stall_left;
	bit  idle_on;
	int  errors;
	int  cycles;
	int  cmd_count;
	int  beat_count;
	int  tick_count;
	int  wake_count;
	int  pause_count;
	logic [31:0] stim_sec;

	function automatic logic [31:0] tokens_add(input logic [31:0] a, input logic [30:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {2'b00, b};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic logic [31:0] tokens_sub(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? a - b : 32'd0;
	endfunction

	function automatic logic throttled(input int i);
		return slot_cells[i] && slot_open[i];
	endfunction

	function automatic limiter_beat_t make_beat(input logic [3:0] slot, input logic [31:0] lim,
			input logic pause, input logic rr, input logic rw, input logic last);
		limiter_beat_t b;
		b.out_slot = slot;
		b.read_limit = lim;
		b.pause_reading = pause;
		b.resume_reading = rr;
		b.resume_writing = rw;
		b.last = last;
		return b;
	endfunction

	// Works out the result beats of one accepted command and updates the shadow state.
	function automatic void limiter_apply(input limiter_cmd_t c);
		logic [31:0] lim;
		logic        pause;
		int          s;
		s = c.slot;
		cmd_count++;
		case (c.mode)
			dtbrl_pkg::MODE_INIT: begin
				stamp_sec = c.seconds;
				glob_tokens = {1'b0, lim_burst};
				awaited_beats.push_back(make_beat(4'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			dtbrl_pkg::MODE_SET: begin
				slot_cells[s] = c.speaks_cells;
				slot_open[s] = c.is_open;
				slot_refill[s] = c.slot_bandwidth;
				slot_tokens[s] = {1'b0, c.slot_bandwidth};
				read_waiting[s] = 1'b0;
				write_waiting[s] = 1'b0;
				awaited_beats.push_back(make_beat(c.slot, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			dtbrl_pkg::MODE_QUERY: begin
				if (lim_pad) begin
					lim = glob_tokens;
				end else begin
					lim = slot_cells[s] ? {16'd0, lim_cell_cap} : {16'd0, lim_stream_cap};
					if (lim > glob_tokens)
						lim = glob_tokens;
				end
				if (throttled(s) && lim > slot_tokens[s])
					lim = slot_tokens[s];
				awaited_beats.push_back(make_beat(c.slot, lim, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			dtbrl_pkg::MODE_CHARGE: begin
				glob_tokens = tokens_sub(glob_tokens, {1'b0, c.byte_count});
				if (throttled(s))
					slot_tokens[s] = tokens_sub(slot_tokens[s], {1'b0, c.byte_count});
				pause = (glob_tokens == 0) || (throttled(s) && slot_tokens[s] == 0);
				if (pause) begin
					read_waiting[s] = 1'b1;
					pause_count++;
				end
				awaited_beats.push_back(make_beat(c.slot, 32'd0, pause, 1'b0, 1'b0, 1'b1));
			end
			dtbrl_pkg::MODE_WBLOCK: begin
				write_waiting[s] = 1'b1;
				awaited_beats.push_back(make_beat(c.slot, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			dtbrl_pkg::MODE_TICK: begin
				tick_count++;
				// A tick that does not move time forward only yields the closing beat.
				if (c.seconds > stamp_sec) begin
					stamp_sec = c.seconds;
					if (glob_tokens < {1'b0, lim_burst})
						glob_tokens = tokens_add(glob_tokens, lim_rate);
					for (int i = 0; i < SLOTS; i++) begin
						if (throttled(i) && {32'd0, slot_tokens[i]} <=
								64'(HEADROOM_SECS) * {33'd0, slot_refill[i]})
							slot_tokens[i] = tokens_add(slot_tokens[i], slot_refill[i]);
						if (read_waiting[i] && glob_tokens > 0 &&
								(!throttled(i) || slot_tokens[i] > 0)) begin
							awaited_beats.push_back(make_beat(4'(i), 32'd0, 1'b0, 1'b1,
								write_waiting[i], 1'b0));
							read_waiting[i] = 1'b0;
							write_waiting[i] = 1'b0;
							wake_count++;
						end
					end
				end
				awaited_beats.push_back(make_beat(4'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			default: begin
				awaited_beats.push_back(make_beat(4'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	function automatic logic [30:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 31'd0;
		if (r < 55)
			return 31'($urandom_range(1, 2000));
		if (r < 85)
			return 31'($urandom_range(2001, 70000));
		if (r < 97)
			return 31'($urandom);
		return 31'h7FFF_FFFF;
	endfunction

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic void push_cmd(input logic [2:0] mode, input logic [3:0] slot,
			input logic [30:0] bytes, input logic [31:0] secs, input logic cells,
			input logic opened, input logic [30:0] bw);
		limiter_cmd_t c;
		c.mode = mode;
		c.slot = slot;
		c.byte_count = bytes;
		c.seconds = secs;
		c.speaks_cells = cells;
		c.is_open = opened;
		c.slot_bandwidth = bw;
		pending_cmds.push_back(c);
	endfunction

	// Command driver: one beat in flight, random gaps between beats while idle_on is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= '0;
			req_ch.slot <= '0;
			req_ch.byte_count <= '0;
			req_ch.seconds <= '0;
			req_ch.speaks_cells <= 1'b0;
			req_ch.is_open <= 1'b0;
			req_ch.slot_bandwidth <= '0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				limiter_apply(in_flight);
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					in_flight = pending_cmds.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.mode <= in_flight.mode;
					req_ch.slot <= in_flight.slot;
					req_ch.byte_count <= in_flight.byte_count;
					req_ch.seconds <= in_flight.seconds;
					req_ch.speaks_cells <= in_flight.speaks_cells;
					req_ch.is_open <= in_flight.is_open;
					req_ch.slot_bandwidth <= in_flight.slot_bandwidth;
					gap_left = idle_on ? pick_gap() : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each beat against the oldest expectation and stalls at random while idle_on is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_beat = {rsp_ch.out_slot, rsp_ch.read_limit, rsp_ch.pause_reading,
					rsp_ch.resume_reading, rsp_ch.resume_writing, rsp_ch.last};
				beat_count++;
				if (awaited_beats.size() == 0) begin
					note_error($sformatf({"unexpected beat: slot=%0d limit=%0d ",
						"pause=%b rr=%b rw=%b last=%b"},
						got_beat.out_slot, got_beat.read_limit, got_beat.pause_reading,
						got_beat.resume_reading, got_beat.resume_writing, got_beat.last));
				end else begin
					want_beat = awaited_beats.pop_front();
					if (got_beat.out_slot !== want_beat.out_slot ||
							got_beat.read_limit !== want_beat.read_limit ||
							got_beat.pause_reading !== want_beat.pause_reading ||
							got_beat.resume_reading !== want_beat.resume_reading ||
							got_beat.resume_writing !== want_beat.resume_writing ||
							got_beat.last !== want_beat.last)
						note_error($sformatf({"beat %0d mismatch: expected slot=%0d limit=%0d ",
							"pause=%b rr=%b rw=%b last=%b, got slot=%0d limit=%0d pause=%b ",
							"rr=%b rw=%b last=%b"}, beat_count,
							want_beat.out_slot, want_beat.read_limit, want_beat.pause_reading,
							want_beat.resume_reading, want_beat.resume_writing, want_beat.last,
							got_beat.out_slot, got_beat.read_limit, got_beat.pause_reading,
							got_beat.resume_reading, got_beat.resume_writing, got_beat.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats still awaited", cycles,
				awaited_beats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input logic [dtbrl_pkg::CFG_IDX_W-1:0] idx,
			input logic [dtbrl_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic set_config(input logic pad, input logic [30:0] rate, input logic [30:0] burst,
			input logic [15:0] ccap, input logic [15:0] scap);
		write_reg(dtbrl_pkg::CFG_LINK_PADDING, {30'd0, pad});
		write_reg(dtbrl_pkg::CFG_REFILL_RATE, rate);
		write_reg(dtbrl_pkg::CFG_BURST_SIZE, burst);
		write_reg(dtbrl_pkg::CFG_CELL_CAP, {15'd0, ccap});
		write_reg(dtbrl_pkg::CFG_STREAM_CAP, {15'd0, scap});
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_pad = pad;
		lim_rate = rate;
		lim_burst = burst;
		lim_cell_cap = ccap;
		lim_stream_cap = scap;
		@(negedge clk);
	endtask

	// Waits until every queued command has gone and every result beat has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || req_ch.valid || awaited_beats.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// A session: init, a few slot setups, then mostly queries, charges and ticks, plus other modes.
	task automatic queue_session(input int n);
		limiter_cmd_t c;
		logic [127:0] rnd;
		logic [3:0]   hot [$];
		int           r;
		int           k;
		rnd = {$urandom, $urandom, $urandom, $urandom};
		c = rnd[$bits(limiter_cmd_t)-1:0];
		c.mode = dtbrl_pkg::MODE_INIT;
		if ($urandom_range(0, 7) == 0)
			stim_sec = $urandom;
		else
			stim_sec = stim_sec + 1;
		c.seconds = stim_sec;
		pending_cmds.push_back(c);
		k = $urandom_range(3, 6);
		repeat (k) begin
			rnd = {$urandom, $urandom, $urandom, $urandom};
			c = rnd[$bits(limiter_cmd_t)-1:0];
			c.mode = dtbrl_pkg::MODE_SET;
			c.speaks_cells = ($urandom_range(0, 9) < 7);
			c.is_open = ($urandom_range(0, 9) < 7);
			c.slot_bandwidth = pick_amount();
			hot.push_back(c.slot);
			pending_cmds.push_back(c);
		end
		repeat (n) begin
			rnd = {$urandom, $urandom, $urandom, $urandom};
			c = rnd[$bits(limiter_cmd_t)-1:0];
			if ($urandom_range(0, 9) < 7)
				c.slot = hot[$urandom_range(0, hot.size() - 1)];
			r = $urandom_range(0, 99);
			if (r < 28) begin
				c.mode = dtbrl_pkg::MODE_QUERY;
			end else if (r < 56) begin
				c.mode = dtbrl_pkg::MODE_CHARGE;
				c.byte_count = pick_amount();
			end else if (r < 64) begin
				c.mode = dtbrl_pkg::MODE_WBLOCK;
			end else if (r < 80) begin
				c.mode = dtbrl_pkg::MODE_TICK;
				k = $urandom_range(0, 9);
				if (k < 8) begin
					stim_sec = stim_sec + $urandom_range(1, 3);
					c.seconds = stim_sec;
				end else if (k < 9) begin
					c.seconds = stim_sec;
				end else begin
					c.seconds = stim_sec - $urandom_range(1, 5);
				end
			end else if (r < 90) begin
				c.mode = dtbrl_pkg::MODE_SET;
				c.slot_bandwidth = pick_amount();
				hot.push_back(c.slot);
			end else if (r < 93) begin
				c.mode = dtbrl_pkg::MODE_INIT;
				stim_sec = stim_sec + 1;
				c.seconds = stim_sec;
			end else begin
				c.mode = $urandom_range(0, 1) ? MODE_SPARE7 : MODE_SPARE6;
			end
			pending_cmds.push_back(c);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = '0;
		req_ch.slot = '0;
		req_ch.byte_count = '0;
		req_ch.seconds = '0;
		req_ch.speaks_cells = 1'b0;
		req_ch.is_open = 1'b0;
		req_ch.slot_bandwidth = '0;
		rsp_ch.ready = 1'b0;
		idle_on = 1'b1;
		errors = 0;
		cycles = 0;
		cmd_count = 0;
		beat_count = 0;
		tick_count = 0;
		wake_count = 0;
		pause_count = 0;
		stim_sec = 32'd10;
		lim_pad = 1'b0;
		lim_rate = '0;
		lim_burst = '0;
		lim_cell_cap = dtbrl_pkg::CELL_CAP_RST;
		lim_stream_cap = dtbrl_pkg::STREAM_CAP_RST;
		glob_tokens = '0;
		stamp_sec = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_tokens[i] = '0;
			slot_refill[i] = '0;
			slot_cells[i] = 1'b0;
			slot_open[i] = 1'b0;
			read_waiting[i] = 1'b0;
			write_waiting[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Straight out of reset: empty buckets, stale tick, unused modes, then slot 15 charged and write-blocked.
		push_cmd(dtbrl_pkg::MODE_QUERY, 4'd0, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_TICK, 4'd0, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(MODE_SPARE6, 4'd0, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(MODE_SPARE7, 4'd0, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_CHARGE, 4'd15, 31'h7FFF_FFFF, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_WBLOCK, 4'd15, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_TICK, 4'd0, 31'd0, 32'd1, 1'b0, 1'b0, 31'd0);
		drain();

		// Slot 15 still waits to read and write, so the first real tick wakes it.
		set_config(1'b0, 31'd3000, 31'd40000, 16'd65535, 16'd1500);
		push_cmd(dtbrl_pkg::MODE_INIT, 4'd0, 31'd0, 32'd5, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_SET, 4'd3, 31'd0, 32'd0, 1'b1, 1'b1, 31'd100);
		push_cmd(dtbrl_pkg::MODE_SET, 4'd1, 31'd0, 32'd0, 1'b1, 1'b1, 31'h7FFF_FFFF);
		push_cmd(dtbrl_pkg::MODE_SET, 4'd0, 31'd0, 32'd0, 1'b1, 1'b0, 31'd12345);
		push_cmd(dtbrl_pkg::MODE_SET, 4'd7, 31'd0, 32'd0, 1'b1, 1'b1, 31'd0);
		push_cmd(dtbrl_pkg::MODE_QUERY, 4'd3, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_QUERY, 4'd0, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_QUERY, 4'd14, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_CHARGE, 4'd3, 31'd60, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_CHARGE, 4'd3, 31'd1000, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_CHARGE, 4'd7, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_WBLOCK, 4'd3, 31'd0, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_TICK, 4'd0, 31'd0, 32'd6, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_TICK, 4'd0, 31'd0, 32'd7, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_CHARGE, 4'd14, 31'h7FFF_FFFF, 32'd0, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_TICK, 4'd0, 31'd0, 32'd8, 1'b0, 1'b0, 31'd0);
		push_cmd(dtbrl_pkg::MODE_TICK, 4'd0, 31'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 31'd0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			idle_on = (phase != 2 && phase != 5);
			case (phase)
				0: set_config(1'b0, 31'd500, 31'd4000, 16'd1000, 16'd700);
				1: set_config(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 16'd0);
				2: set_config(1'b0, 31'd0, 31'd0, 16'hFFFF, 16'hFFFF);
				3: set_config(1'($urandom), 31'($urandom_range(0, 100000)),
					31'($urandom_range(0, 200000)), 16'($urandom), 16'($urandom));
				4: set_config(1'b1, 31'($urandom), 31'($urandom),
					dtbrl_pkg::CELL_CAP_RST, dtbrl_pkg::STREAM_CAP_RST);
				default: set_config(1'b0, 31'd20000, 31'd60000, 16'd16384, 16'd15936);
			endcase
			queue_session(36);
			drain();
		end

		repeat (20) @(negedge clk);
		$display({"Checked %0d result beats from %0d commands: ",
			"%0d ticks, %0d slot wakes, %0d pauses."},
			beat_count, cmd_count, tick_count, wake_count, pause_count);
		$display({"Register sets ranged from empty buckets to full-range rates ",
			"and zero caps; %0d errors."}, errors);
		if (errors == 0 && awaited_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> dual_token_bucket_read_limiter_unit.f
hw/rtl/dtbrl_pkg.sv
hw/rtl/dtbrl_if.sv
hw/rtl/dtbrl_ctrl.sv
hw/rtl/dtbrl_dp.sv
hw/rtl/dual_token_bucket_read_limiter_unit.sv
hw/rtl/dtbrl_checker.sv
tb/dual_token_bucket_read_limiter_unit_test.sv
